### sv/scan_ring_buffer_macros.svh
// Assertion macros used by the scan ring buffer checker.
`ifndef SCAN_RING_BUFFER_MACROS_SVH
`define SCAN_RING_BUFFER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define SRB_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scan_ring_buffer check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define SRB_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scan_ring_buffer check failed");

`endif

### sv/srb_pkg.sv
// Shared constants, codes and controller/datapath types of the scan ring buffer.
`default_nettype none

package srb_pkg;

	// Slot count and slot size are powers of two: store address is {slot, point}.
	localparam int SLOTS      = 8;
	localparam int MAX_POINTS = 2048;
	localparam int SLOT_W     = $clog2(SLOTS);
	localparam int PT_W       = $clog2(MAX_POINTS);
	localparam int ADDR_W     = SLOT_W + PT_W;
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);
	localparam int HELD_W     = $clog2(SLOTS + 1);

	localparam int RES_W   = 7;
	localparam int LEN_W   = 12;
	localparam int DATA_W  = 16;
	localparam int ANGLE_W = 16;
	localparam int STAT_W  = 2;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	// Divider: dividend 2*angle+res, divisor 2*res.
	localparam int NUM_W  = 16;
	localparam int DEN_W  = RES_W + 1;
	localparam int STEP_W = $clog2(NUM_W);

	localparam logic [RES_W-1:0] RES_RESET = 7'd100;
	localparam logic [LEN_W-1:0] LEN_RESET = 12'd181;
	localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = 16'sd18000;

	typedef enum logic [1:0] {
		KIND_WRITE = 2'd0,
		KIND_READ  = 2'd1,
		KIND_QUERY = 2'd2,
		KIND_CLEAR = 2'd3
	} kind_t;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

	// Register select is paddr[2].
	localparam logic REG_RES = 1'b0;
	localparam logic REG_LEN = 1'b1;

	typedef struct packed {
		logic write;
		logic read;
		logic clear;
		logic q_err;
		logic q_start;
		logic div_step;
		logic lookup;
	} srb_cmd_t;

	typedef struct packed {
		logic query_ok;
	} srb_stat_t;

endpackage

`default_nettype wire

### sv/srb_ctrl.sv
// Controller state machine of the scan ring buffer: item decode and query sequencing.
`default_nettype none

module srb_ctrl
	import srb_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic [1:0]      kind,
	input  wire srb_stat_t       stat,
	output srb_cmd_t             cmd,
	output logic                 busy
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIVIDE,
		S_LOOKUP
	} state_t;

	state_t             state_q;
	logic [STEP_W-1:0]  step_q;
	logic               busy_q;
	kind_t              kind_in;

	assign kind_in = kind_t'(kind);
	assign busy    = busy_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					unique case (kind_in)
						KIND_WRITE: cmd.write = 1'b1;
						KIND_READ:  cmd.read  = 1'b1;
						KIND_CLEAR: cmd.clear = 1'b1;
						KIND_QUERY: begin
							if (stat.query_ok) cmd.q_start = 1'b1;
							else cmd.q_err = 1'b1;
						end
					endcase
				end
			end
			S_DIVIDE: cmd.div_step = 1'b1;
			S_LOOKUP: cmd.lookup   = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			busy_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.q_start) begin
						state_q <= S_DIVIDE;
						step_q  <= '0;
						busy_q  <= 1'b1;
					end
				end
				S_DIVIDE: begin
					step_q <= step_q + STEP_W'(1);
					// one quotient bit per cycle
					if (step_q == STEP_W'(NUM_W - 1)) state_q <= S_LOOKUP;
				end
				S_LOOKUP: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### sv/srb_dp.sv
// Datapath of the scan ring buffer: scan store, ring pointers, divider and result registers.
`default_nettype none

module srb_dp
	import srb_pkg::*;
(
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire srb_cmd_t                    cmd,
	output srb_stat_t                        stat,
	input  wire logic [DATA_W-1:0]           reading,
	input  wire logic                        end_of_scan,
	input  wire logic signed [ANGLE_W-1:0]   angle_centideg,
	input  wire logic [RES_W-1:0]            res_cfg,
	input  wire logic [LEN_W-1:0]            len_cfg,
	output logic                             strobe,
	output logic [DATA_W-1:0]                distance,
	output logic [STAT_W-1:0]                status,
	output logic                             last_of_scan
);

	logic [DATA_W-1:0] mem [SLOTS*MAX_POINTS];

	logic [CNT_W-1:0]  fill_q [SLOTS];
	logic [SLOT_W-1:0] wslot_q;
	logic [HELD_W-1:0] held_q;
	logic [CNT_W-1:0]  wcur_q;
	logic [CNT_W-1:0]  rcur_q;

	logic [NUM_W-1:0]  num_q;
	logic [DEN_W-1:0]  den_q;
	logic [DEN_W-1:0]  rem_q;

	logic [DATA_W-1:0] rdata_q;
	logic              hit_q;
	logic              strobe_q;
	logic              last_q;
	logic [STAT_W-1:0] status_q;

	logic [CNT_W-1:0]  len;
	logic [CNT_W-1:0]  len_m1;
	logic [RES_W-1:0]  res_eff;
	logic              empty;
	logic              full;
	logic [SLOT_W-1:0] oldest;
	logic [SLOT_W-1:0] newest;
	logic [SLOT_W-1:0] fsel;
	logic [CNT_W-1:0]  fill_sel;
	logic              wr_room;
	logic [CNT_W-1:0]  wcur_inc;
	logic              angle_bad;
	logic              rd_last;
	logic [DEN_W:0]    trial;
	logic              ge;
	logic [DEN_W:0]    diff;
	logic [CNT_W-1:0]  idx;
	logic [CNT_W-1:0]  pos_sel;
	logic              hit;
	logic [ADDR_W-1:0] rd_addr;
	logic [ADDR_W-1:0] wr_addr;
	logic [NUM_W-1:0]  num_init;

	always_comb begin
		if (len_cfg == '0) len = CNT_W'(1);
		else if (len_cfg > LEN_W'(MAX_POINTS)) len = CNT_W'(MAX_POINTS);
		else len = CNT_W'(len_cfg);
	end

	assign len_m1   = len - CNT_W'(1);
	assign res_eff  = (res_cfg == '0) ? RES_W'(1) : res_cfg;
	assign empty    = (held_q == '0);
	assign full     = (held_q == HELD_W'(SLOTS));
	// slot count is a power of two: subtract modulo SLOTS
	assign oldest   = wslot_q - SLOT_W'(held_q);
	assign newest   = wslot_q - SLOT_W'(1);
	assign fsel     = cmd.lookup ? newest : oldest;
	assign fill_sel = fill_q[fsel];
	assign wr_room  = (wcur_q < len);
	assign wcur_inc = wcur_q + CNT_W'(1);
	assign rd_last  = (rcur_q >= len_m1);

	assign angle_bad = (angle_centideg < 0) || (angle_centideg > ANGLE_MAX);
	assign stat.query_ok = !angle_bad && !empty;

	// 2*angle + res, angle known to lie in 0..18000 here
	assign num_init = {angle_centideg[ANGLE_W-2:0], 1'b0} + NUM_W'(res_eff);

	// restoring division step
	assign trial = {rem_q, num_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = (trial >= {1'b0, den_q});

	// clamp quotient to the last reading of the scan
	assign idx = (num_q > NUM_W'(len_m1)) ? len_m1 : CNT_W'(num_q);

	assign pos_sel = cmd.lookup ? idx : rcur_q;
	assign hit     = (pos_sel < fill_sel);
	assign rd_addr = cmd.lookup ? {newest, idx[PT_W-1:0]} : {oldest, rcur_q[PT_W-1:0]};
	assign wr_addr = {wslot_q, wcur_q[PT_W-1:0]};

	always_ff @(posedge clk) begin
		if (cmd.write && wr_room) mem[wr_addr] <= reading;
		if (cmd.read || cmd.lookup) rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.q_start) begin
			num_q <= num_init;
			den_q <= {res_eff, 1'b0};
			rem_q <= '0;
		end else if (cmd.div_step) begin
			num_q <= {num_q[NUM_W-2:0], ge};
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) fill_q[i] <= '0;
			wslot_q  <= '0;
			held_q   <= '0;
			wcur_q   <= '0;
			rcur_q   <= '0;
			strobe_q <= 1'b0;
			hit_q    <= 1'b0;
			last_q   <= 1'b0;
			status_q <= ST_OK;
		end else begin
			strobe_q <= cmd.read || cmd.q_err || cmd.lookup;
			if (cmd.clear) begin
				for (int i = 0; i < SLOTS; i++) fill_q[i] <= '0;
				wslot_q <= '0;
				held_q  <= '0;
				wcur_q  <= '0;
				rcur_q  <= '0;
			end else if (cmd.write) begin
				// drop readings past the scan length, still honor the end mark
				if (wr_room) wcur_q <= wcur_inc;
				if (end_of_scan) begin
					fill_q[wslot_q] <= wr_room ? wcur_inc : wcur_q;
					wcur_q  <= '0;
					wslot_q <= wslot_q + SLOT_W'(1);
					if (full) rcur_q <= '0;
					else held_q <= held_q + HELD_W'(1);
				end
			end else if (cmd.read) begin
				if (empty) begin
					status_q <= ST_EMPTY;
					hit_q    <= 1'b0;
					last_q   <= 1'b0;
				end else begin
					status_q <= ST_OK;
					hit_q    <= hit;
					if (rd_last) begin
						last_q <= 1'b1;
						rcur_q <= '0;
						held_q <= held_q - HELD_W'(1);
					end else begin
						last_q <= 1'b0;
						rcur_q <= rcur_q + CNT_W'(1);
					end
				end
			end else if (cmd.q_err) begin
				// range check wins over empty
				status_q <= angle_bad ? ST_RANGE : ST_EMPTY;
				hit_q    <= 1'b0;
				last_q   <= 1'b0;
			end else if (cmd.lookup) begin
				status_q <= ST_OK;
				hit_q    <= hit;
				last_q   <= 1'b0;
			end
		end
	end

	assign strobe       = strobe_q;
	assign distance     = hit_q ? rdata_q : '0;
	assign status       = status_q;
	assign last_of_scan = last_q;

endmodule

`default_nettype wire

### sv/scan_ring_buffer.sv
// Top level of the scan ring buffer: configuration registers, controller and datapath.
// Write and clear items: no result, busy stays low.
// Read items: strobe in the cycle after acceptance; one item per cycle while busy is low.
// Distance queries: out-of-range or empty answers in the cycle after acceptance; otherwise
// busy is high through the 16-step serial divider and the store read; the strobe follows.
// Reset clears pointers, fill counts and registers (resolution 100, length 181); store contents
// stay undefined; unwritten locations may be read, but their data is masked to zero.
`default_nettype none

module scan_ring_buffer
	import srb_pkg::*;
(
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [PADDR_W-1:0]          paddr,
	input  wire logic [PDATA_W-1:0]          pwdata,
	output logic [PDATA_W-1:0]               prdata,
	output logic                             pready,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic [1:0]                  kind,
	input  wire logic [DATA_W-1:0]           reading,
	input  wire logic                        end_of_scan,
	input  wire logic signed [ANGLE_W-1:0]   angle_centideg,
	output logic                             strobe,
	output logic [DATA_W-1:0]                distance,
	output logic [STAT_W-1:0]                status,
	output logic                             last_of_scan
);

	logic [RES_W-1:0] res_q;
	logic [LEN_W-1:0] len_q;
	srb_cmd_t         cmd;
	srb_stat_t        stat;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= RES_RESET;
			len_q <= LEN_RESET;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[2])
				REG_RES: res_q <= pwdata[RES_W-1:0];
				REG_LEN: len_q <= pwdata[LEN_W-1:0];
			endcase
		end
	end

	assign prdata = (paddr[2] == REG_LEN) ? PDATA_W'(len_q) : PDATA_W'(res_q);

	srb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (kind),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	srb_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.reading        (reading),
		.end_of_scan    (end_of_scan),
		.angle_centideg (angle_centideg),
		.res_cfg        (res_q),
		.len_cfg        (len_q),
		.strobe         (strobe),
		.distance       (distance),
		.status         (status),
		.last_of_scan   (last_of_scan)
	);

endmodule

`default_nettype wire

### sv/srb_checker.sv
// Port-level checker of the scan ring buffer and its bind to the top level.
`default_nettype none

`include "scan_ring_buffer_macros.svh"

module srb_checker
	import srb_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              start,
	input wire logic              busy,
	input wire logic [1:0]        kind,
	input wire logic              strobe,
	input wire logic [DATA_W-1:0] distance,
	input wire logic [STAT_W-1:0] status,
	input wire logic              last_of_scan
);

	// a result only follows an accepted transaction or a running query
	`SRB_ASSERT_NOW(a_strobe_cause, strobe, $past(busy) || $past(start && !busy))

	// error results carry no reading and never close a scan
	`SRB_ASSERT_NOW(a_err_zero, strobe && (status != ST_OK), (distance == '0) && !last_of_scan)

	// write and clear complete at once without a result
	`SRB_ASSERT_NEXT(a_wr_clr_quiet, start && !busy && ((kind == KIND_WRITE) || (kind == KIND_CLEAR)), !strobe && !busy)

	// a read answers in the next cycle and leaves the block free
	`SRB_ASSERT_NEXT(a_read_answer, start && !busy && (kind == KIND_READ), strobe && !busy)

	// a query either answers at once or starts the divider
	`SRB_ASSERT_NEXT(a_query_goes, start && !busy && (kind == KIND_QUERY), strobe != busy)

endmodule

bind scan_ring_buffer srb_checker u_srb_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.kind         (kind),
	.strobe       (strobe),
	.distance     (distance),
	.status       (status),
	.last_of_scan (last_of_scan)
);

`default_nettype wire
